@@ hdl/sles_pkg.sv @@
// Shared types, character codes and defaults for the string literal extent scanner.
package sles_pkg;

    localparam int DEF_MAX_TEXT_LEN = 4096;
    localparam int FIELD_W          = 13;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;

    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_SQ3    = 2'd1;
    localparam logic [1:0] KIND_DQ3    = 2'd2;

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_HASH,
        SC_OPEN,
        SC_TAG,
        SC_BODY,
        SC_ESC,
        SC_ESC_END,
        SC_TERM,
        SC_DONE
    } scan_state_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [1:0]         kind;
        logic [FIELD_W-1:0] hash_count;
        logic [FIELD_W-1:0] prefix_length;
        logic [FIELD_W-1:0] literal_length;
        logic               terminated;
    } scan_res_t;

endpackage

@@ hdl/string_literal_extent_scanner_core.sv @@
// Top level of the string literal extent scanner: load path, text buffer and result register.
//
// Bytes of source text are taken on the s_ channel one per cycle and written
// into a buffer of MAX_TEXT_LEN bytes; bytes beyond that are dropped and the
// overflowed flag is set. The byte with s_tlast starts a scan of the buffer,
// during which s_tready is low. The scan reads the single read port of the buffer
// one byte at a time and evaluates it in the next cycle; the closing check of an
// escape's hashes and the final end or terminator check are made without a
// read, and the result is then registered. A backslash or quote that turns out
// not to start an escape or the terminator causes the bytes after it (at most
// the hash count plus two) to be read again; a failed triple-double-quote
// opener restarts the scan just after the first quote, and a failed
// triple-single-quote opener ends it. One result appears on the m_ channel per
// text; loading of the next text starts as soon as the result is registered,
// even while it waits to be taken. A scan that ends while the previous result
// is still waiting holds in its last cycle until that result is taken.
module string_literal_extent_scanner_core
    import sles_pkg::*;
#(
    parameter int MAX_TEXT_LEN = DEF_MAX_TEXT_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] src_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] found, [2:1] kind, [15:3] hash_count, [28:16] prefix_length,
    // [41:29] literal_length, [42] terminated, [43] overflowed, [47:44] zero
    output logic [47:0] m_tdata
);

    localparam int AW = $clog2(MAX_TEXT_LEN);
    localparam int CW = $clog2(MAX_TEXT_LEN + 1);

    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic          scan_ovf_reg;
    logic          m_valid_reg, m_valid_next;
    logic [47:0]   m_data_reg;

    logic          accept;
    logic          full;
    logic          start;
    logic [CW-1:0] n_in;
    logic          scan_idle;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    scan_res_t     res;
    logic          res_ready;

    assign full      = fill_reg == CW'(MAX_TEXT_LEN);
    assign s_tready  = scan_idle;
    assign accept    = s_tvalid && s_tready;
    assign start     = accept && s_tlast;
    assign n_in      = full ? fill_reg : CW'(fill_reg + 1'b1);
    assign res_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        fill_next    = fill_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        if (accept) begin
            if (s_tlast) begin
                fill_next = '0;
                ovf_next  = 1'b0;
            end else if (full) begin
                ovf_next = 1'b1;
            end else begin
                fill_next = CW'(fill_reg + 1'b1);
            end
        end
        if (res.valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            scan_ovf_reg <= ovf_reg || full;
        end
        if (res.valid && res_ready) begin
            m_data_reg <= {4'b0, scan_ovf_reg, res.terminated, res.literal_length,
                           res.prefix_length, res.hash_count, res.kind, res.found};
        end
    end

    sles_ram #(
        .WIDTH(8),
        .DEPTH(MAX_TEXT_LEN)
    ) u_text_ram (
        .aclk   (aclk),
        .wr_en  (accept && !full),
        .wr_addr(fill_reg[AW-1:0]),
        .wr_data(s_tdata),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    sles_scan #(
        .MAX_TEXT_LEN(MAX_TEXT_LEN)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .n_in     (n_in),
        .idle     (scan_idle),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .res      (res),
        .res_ready(res_ready)
    );

    a_ovf_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> full)
        else $error("overflow flagged while the buffer has room");

endmodule

@@ hdl/sles_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module sles_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/sles_scan.sv @@
// Scan sequencer: walks the text buffer one byte per read and measures the literal.
module sles_scan
    import sles_pkg::*;
#(
    parameter int MAX_TEXT_LEN = DEF_MAX_TEXT_LEN
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [$clog2(MAX_TEXT_LEN+1)-1:0]   n_in,
    output logic                                idle,
    output logic                                rd_en,
    output logic [$clog2(MAX_TEXT_LEN)-1:0]     rd_addr,
    input  logic [7:0]                          rd_data,
    output scan_res_t                           res,
    input  logic                                res_ready
);

    localparam int AW = $clog2(MAX_TEXT_LEN);
    localparam int CW = $clog2(MAX_TEXT_LEN + 1);
    localparam int TW = CW + 2;

    scan_state_t   state_reg, state_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] h_reg, h_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] prefix_reg, prefix_next;
    logic [CW-1:0] length_reg, length_next;
    logic [1:0]    kind_reg, kind_next;
    logic          found_reg, found_next;
    logic          term_reg, term_next;

    logic          at_end;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] retry_pos;
    logic [7:0]    quote;
    logic [TW-1:0] qlen_w;
    logic [TW-1:0] term_total;
    logic          esc_hit;
    logic          term_hit;
    logic          open_fail;

    assign at_end     = pos_reg >= n_reg;
    assign pos_inc    = CW'(pos_reg + 1'b1);
    assign retry_pos  = CW'(start_reg + 1'b1);
    assign quote      = (kind_reg == KIND_SQ3) ? CH_SQ : CH_DQ;
    assign qlen_w     = (kind_reg == KIND_SINGLE) ? TW'(1) : TW'(3);
    assign term_total = TW'(h_reg) + qlen_w;
    assign esc_hit    = k_reg == h_reg;
    assign term_hit   = TW'(k_reg) == term_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        n_reg      <= n_next;
        h_reg      <= h_next;
        k_reg      <= k_next;
        start_reg  <= start_next;
        prefix_reg <= prefix_next;
        length_reg <= length_next;
        kind_reg   <= kind_next;
        found_reg  <= found_next;
        term_reg   <= term_next;
    end

    // Next state. Each byte is handled as a read request followed by evaluation of the data.
    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        pos_next    = pos_reg;
        n_next      = n_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        start_next  = start_reg;
        prefix_next = prefix_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        found_next  = found_reg;
        term_next   = term_reg;
        open_fail   = 1'b0;

        case (state_reg)
            SC_IDLE: begin
                if (start) begin
                    state_next  = SC_HASH;
                    pend_next   = 1'b0;
                    pos_next    = '0;
                    n_next      = n_in;
                    h_next      = '0;
                    k_next      = '0;
                    start_next  = '0;
                    prefix_next = '0;
                    length_next = '0;
                    kind_next   = KIND_SINGLE;
                    found_next  = 1'b0;
                    term_next   = 1'b0;
                end
            end
            SC_HASH: begin
                if (!pend_reg) begin
                    if (at_end) begin
                        h_next     = pos_reg;
                        state_next = SC_DONE;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (rd_data == CH_HASH) begin
                        pos_next = pos_inc;
                    end else begin
                        h_next   = pos_reg;
                        pos_next = pos_inc;
                        k_next   = CW'(1);
                        if (rd_data == CH_SQ) begin
                            kind_next  = KIND_SQ3;
                            state_next = SC_OPEN;
                        end else if (rd_data == CH_DQ) begin
                            kind_next  = KIND_DQ3;
                            state_next = SC_OPEN;
                        end else begin
                            state_next = SC_DONE;
                        end
                    end
                end
            end
            SC_OPEN: begin
                if (!pend_reg) begin
                    if (at_end) begin
                        open_fail = 1'b1;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (rd_data == quote) begin
                        pos_next = pos_inc;
                        if (k_reg == CW'(2)) begin
                            state_next = SC_TAG;
                        end else begin
                            k_next = CW'(k_reg + 1'b1);
                        end
                    end else begin
                        open_fail = 1'b1;
                    end
                end
            end
            SC_TAG: begin
                if (!pend_reg) begin
                    if (at_end) begin
                        open_fail = 1'b1;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (rd_data == CH_NL) begin
                        found_next  = 1'b1;
                        prefix_next = pos_inc;
                        pos_next    = pos_inc;
                        state_next  = SC_BODY;
                    end else if (rd_data == CH_HASH || rd_data == CH_DQ) begin
                        open_fail = 1'b1;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end
            SC_BODY: begin
                if (!pend_reg) begin
                    if (at_end) begin
                        length_next = n_reg;
                        state_next  = SC_DONE;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (rd_data == CH_BSL) begin
                        start_next = pos_reg;
                        pos_next   = pos_inc;
                        k_next     = '0;
                        state_next = SC_ESC;
                    end else if (rd_data == CH_NL) begin
                        if (kind_reg == KIND_SINGLE) begin
                            length_next = pos_reg;
                            state_next  = SC_DONE;
                        end else begin
                            pos_next = pos_inc;
                        end
                    end else if (rd_data == quote) begin
                        start_next = pos_reg;
                        pos_next   = pos_inc;
                        k_next     = CW'(1);
                        state_next = SC_TERM;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end
            SC_ESC: begin
                if (!pend_reg) begin
                    if (esc_hit) begin
                        state_next = SC_ESC_END;
                    end else if (at_end) begin
                        pos_next   = retry_pos;
                        state_next = SC_BODY;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (rd_data == CH_HASH) begin
                        k_next   = CW'(k_reg + 1'b1);
                        pos_next = pos_inc;
                    end else begin
                        pos_next   = retry_pos;
                        state_next = SC_BODY;
                    end
                end
            end
            SC_ESC_END: begin
                // The cursor sits on the byte that the escape skips.
                if (!pend_reg) begin
                    if (at_end) begin
                        length_next = pos_reg;
                        state_next  = SC_DONE;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (kind_reg == KIND_SINGLE && rd_data == CH_NL) begin
                        length_next = pos_reg;
                        state_next  = SC_DONE;
                    end else begin
                        pos_next   = pos_inc;
                        state_next = SC_BODY;
                    end
                end
            end
            SC_TERM: begin
                if (!pend_reg) begin
                    if (term_hit) begin
                        length_next = pos_reg;
                        term_next   = 1'b1;
                        state_next  = SC_DONE;
                    end else if (at_end) begin
                        pos_next   = retry_pos;
                        state_next = SC_BODY;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    if (rd_data == ((TW'(k_reg) < qlen_w) ? quote : CH_HASH)) begin
                        k_next   = CW'(k_reg + 1'b1);
                        pos_next = pos_inc;
                    end else begin
                        pos_next   = retry_pos;
                        state_next = SC_BODY;
                    end
                end
            end
            SC_DONE: begin
                if (res_ready) begin
                    state_next = SC_IDLE;
                end
            end
            default: begin
                state_next = SC_IDLE;
                pend_next  = 1'b0;
            end
        endcase

        // A failed DQ3 opener falls back to a plain double quote; SQ3 ends the scan.
        if (open_fail) begin
            if (kind_reg == KIND_DQ3) begin
                found_next  = 1'b1;
                kind_next   = KIND_SINGLE;
                prefix_next = CW'(h_reg + 1'b1);
                pos_next    = CW'(h_reg + 1'b1);
                state_next  = SC_BODY;
            end else begin
                kind_next  = KIND_SINGLE;
                state_next = SC_DONE;
            end
        end
    end

    // Outputs.
    always_comb begin
        rd_addr = pos_reg[AW-1:0];
        rd_en   = 1'b0;
        idle    = state_reg == SC_IDLE;
        case (state_reg)
            SC_HASH, SC_OPEN, SC_TAG, SC_BODY, SC_ESC_END: rd_en = !pend_reg && !at_end;
            SC_ESC:  rd_en = !pend_reg && !at_end && !esc_hit;
            SC_TERM: rd_en = !pend_reg && !at_end && !term_hit;
            default: rd_en = 1'b0;
        endcase

        res.valid          = state_reg == SC_DONE;
        res.found          = found_reg;
        res.kind           = found_reg ? kind_reg : KIND_SINGLE;
        res.hash_count     = found_reg ? FIELD_W'(h_reg) : '0;
        res.prefix_length  = found_reg ? FIELD_W'(prefix_reg) : '0;
        res.literal_length = found_reg ? FIELD_W'(length_reg) : '0;
        res.terminated     = found_reg && term_reg;
    end

    a_pos_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != SC_IDLE) |-> (pos_reg <= n_reg))
        else $error("scan cursor ran past the end of the text");

    a_read_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (pos_reg < n_reg))
        else $error("buffer read beyond the bytes held");

    a_read_then_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> pend_reg)
        else $error("read data was not evaluated in the following cycle");

endmodule

@@ test/tb_string_literal_extent_scanner_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the string literal extent scanner core.
module tb_string_literal_extent_scanner_core;
    import sles_pkg::*;

    localparam int TEXT_CAP      = DEF_MAX_TEXT_LEN;
    localparam int RANDOM_BYTES  = 1550;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 100;

    // Same layout as m_tdata, lowest field last.
    typedef struct packed {
        logic [3:0]         pad;
        logic               overflowed;
        logic               terminated;
        logic [FIELD_W-1:0] literal_length;
        logic [FIELD_W-1:0] prefix_length;
        logic [FIELD_W-1:0] hash_count;
        logic [1:0]         kind;
        logic               found;
    } extent_t;

    class literal_scoreboard;
        logic [7:0]  text_mem [TEXT_CAP];
        int          held;
        bit          spilled;
        extent_t     extent_q [$];
        int unsigned errors, texts, checked, with_opener, closed, spills;
        int unsigned kind_hits [3];

        function bit is_run(int pos, logic [7:0] ch, int count);
            if (pos > held || count > held - pos) return 0;
            for (int i = 0; i < count; i++) begin
                if (text_mem[pos + i] != ch) return 0;
            end
            return 1;
        endfunction

        function extent_t predict_extent();
            extent_t    r;
            int         n, h, p, prefix, length, qlen, cur;
            logic [1:0] kind;
            logic [7:0] quote, c;
            bit         found, term;
            n = held;
            h = 0;
            while (h < n && text_mem[h] == CH_HASH) h++;
            kind = KIND_SINGLE;
            quote = CH_DQ;
            qlen = 1;
            found = 0;
            term = 0;
            prefix = 0;
            if (is_run(h, CH_SQ, 3)) begin
                kind = KIND_SQ3;
                quote = CH_SQ;
            end else if (is_run(h, CH_DQ, 3)) begin
                kind = KIND_DQ3;
            end
            if (kind != KIND_SINGLE) begin
                p = h + 3;
                while (p < n && text_mem[p] != CH_HASH && text_mem[p] != CH_NL &&
                       text_mem[p] != CH_DQ) p++;
                if (p < n && text_mem[p] == CH_NL) begin
                    found = 1;
                    prefix = p + 1;
                    qlen = 3;
                end
            end
            // A plain double quote opens the literal; a spoiled triple-double-quote tag falls back to it.
            if (!found && h < n && text_mem[h] == CH_DQ) begin
                found = 1;
                kind = KIND_SINGLE;
                quote = CH_DQ;
                qlen = 1;
                prefix = h + 1;
            end
            r = '0;
            r.overflowed = spilled;
            if (!found) return r;

            length = n;
            cur = prefix;
            while (cur < n) begin
                c = text_mem[cur];
                if (c == CH_BSL) begin
                    if (is_run(cur + 1, CH_HASH, h)) begin
                        cur += 1 + h;
                        if (cur >= n || (kind == KIND_SINGLE && text_mem[cur] == CH_NL)) begin
                            length = cur;
                            break;
                        end
                    end
                end else if (c == CH_NL) begin
                    if (kind == KIND_SINGLE) begin
                        length = cur;
                        break;
                    end
                end else if (c == quote && is_run(cur, quote, qlen) &&
                             is_run(cur + qlen, CH_HASH, h)) begin
                    length = cur + qlen + h;
                    term = 1;
                    break;
                end
                cur++;
            end
            r.found = 1'b1;
            r.kind = kind;
            r.hash_count = FIELD_W'(h);
            r.prefix_length = FIELD_W'(prefix);
            r.literal_length = FIELD_W'(length);
            r.terminated = term;
            return r;
        endfunction

        function void note_request(logic [7:0] b, logic last);
            extent_t r;
            if (held < TEXT_CAP) begin
                text_mem[held] = b;
                held++;
            end else begin
                spilled = 1;
            end
            if (last) begin
                r = predict_extent();
                extent_q.push_back(r);
                texts++;
                with_opener += r.found;
                closed += r.terminated;
                spills += r.overflowed;
                if (r.found) kind_hits[r.kind]++;
                held = 0;
                spilled = 0;
            end
        endfunction

        function int pending();
            return extent_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at result %0d: %s", checked, msg);
            errors++;
        endtask

        task check_result(logic [47:0] data);
            extent_t            got, want;
            logic [FIELD_W-1:0] g [8];
            logic [FIELD_W-1:0] w [8];
            string              names [8];
            names = '{"found", "kind", "hash_count", "prefix_length", "literal_length",
                      "terminated", "overflowed", "padding"};
            got = extent_t'(data);
            checked++;
            if (extent_q.size() == 0) begin
                report("result request arrived with no text pending");
                return;
            end
            want = extent_q.pop_front();
            g = '{got.found, got.kind, got.hash_count, got.prefix_length,
                  got.literal_length, got.terminated, got.overflowed, got.pad};
            w = '{want.found, want.kind, want.hash_count, want.prefix_length,
                  want.literal_length, want.terminated, want.overflowed, want.pad};
            for (int i = 0; i < 8; i++) begin
                if (g[i] !== w[i])
                    report($sformatf("%s got %0d expected %0d", names[i], g[i], w[i]));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    literal_scoreboard board = new();
    logic [7:0]        text_q [$];
    int                burst_left;
    int                cycle_count;
    int                stall_left;
    int                stall_mode;
    int                rx_tick;

    string_literal_extent_scanner_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, board.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check on each accepted result, then pick the next ready value.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 300);
        end
        stall_left--;
        rx_tick++;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_tick % 7) < 5);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(b, last);
        burst_left--;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        send_text();
    endtask

    // Hold the sender off until every predicted result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic push_run(input logic [7:0] ch, input int count);
        repeat (count) text_q.push_back(ch);
    endtask

    // Filler that can neither close, escape nor end a literal.
    task automatic fill_plain(input int size);
        logic [7:0] b;
        while (text_q.size() < size) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_DQ || b == CH_SQ || b == CH_NL || b == CH_BSL) b = 8'h2E;
            text_q.push_back(b);
        end
    endtask

    task automatic build_random_text();
        int         h, style, qlen;
        logic [7:0] qc, other, b;
        text_q.delete();
        style = $urandom_range(0, 99);
        if (style < 8) begin
            repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
        push_run(CH_HASH, h);
        qc = CH_DQ;
        qlen = 1;
        if (style < 50) begin
            text_q.push_back(CH_DQ);
        end else begin
            qc = (style < 75) ? CH_SQ : CH_DQ;
            qlen = 3;
            push_run(qc, 3);
            repeat ($urandom_range(0, 4)) begin
                b = 8'($urandom_range(0, 255));
                text_q.push_back((b == CH_HASH || b == CH_NL || b == CH_DQ) ? 8'h61 : b);
            end
            // Now and then the tag is spoiled, which demotes or drops the opener.
            case ($urandom_range(0, 7))
                0: begin
                    text_q.push_back(CH_HASH);
                    text_q.push_back(CH_NL);
                end
                1: begin
                    text_q.push_back(CH_DQ);
                    text_q.push_back(CH_NL);
                end
                2: ;
                default: text_q.push_back(CH_NL);
            endcase
        end
        other = (qc == CH_DQ) ? CH_SQ : CH_DQ;
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 6))
                    text_q.push_back(8'($urandom_range(0, 255)));
                3: begin
                    text_q.push_back(CH_BSL);
                    push_run(CH_HASH, h);
                    case ($urandom_range(0, 3))
                        0: text_q.push_back(CH_NL);
                        1: text_q.push_back(qc);
                        2: text_q.push_back(CH_BSL);
                        default: text_q.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                4: begin
                    text_q.push_back(CH_BSL);
                    push_run(CH_HASH, (h == 0) ? 0 : $urandom_range(0, h - 1));
                end
                5: if (qlen == 3 || $urandom_range(0, 2) == 0) text_q.push_back(CH_NL);
                6: begin
                    push_run(qc, (qlen == 3) ? $urandom_range(1, 3) : 1);
                    push_run(CH_HASH, (h == 0) ? 0 : $urandom_range(0, h - 1));
                end
                7: begin
                    push_run(other, qlen);
                    push_run(CH_HASH, h);
                end
                8: push_run(CH_HASH, $urandom_range(1, 3));
                default: repeat ($urandom_range(1, 8))
                    text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1: ;
            2: begin
                text_q.push_back(CH_BSL);
                push_run(CH_HASH, h);
            end
            default: begin
                push_run(qc, qlen);
                push_run(CH_HASH, h);
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial begin
        int random_bytes;
        bit mid_drained;
        random_bytes = 0;
        mid_drained = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_string("\"");
        send_string("#\"a\"#");
        send_string("'''\n'''");
        send_string("\"\n");
        send_string("\"\\");
        send_string("\"\\\n");
        send_string("\"\"\"#\n");
        send_string("'''x");
        text_q = {8'hFF};
        send_text();
        text_q = {8'h00};
        send_text();
        drain();

        // A text that fills the buffer exactly and closes on its final byte.
        text_q.delete();
        push_run(CH_HASH, 3);
        text_q.push_back(CH_DQ);
        fill_plain(TEXT_CAP - 4);
        text_q.push_back(CH_DQ);
        push_run(CH_HASH, 3);
        send_text();
        // One byte too many: the final byte is dropped but still starts the scan.
        text_q.delete();
        push_run(CH_HASH, 2);
        push_run(CH_SQ, 3);
        text_q.push_back(CH_NL);
        fill_plain(TEXT_CAP + 1);
        send_text();
        drain();

        while (random_bytes < RANDOM_BYTES) begin
            build_random_text();
            send_text();
            random_bytes += text_q.size();
            if (!mid_drained && random_bytes >= RANDOM_BYTES / 2) begin
                drain();
                mid_drained = 1;
            end
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Scanned %0d texts: %0d with an opener, %0d closed, %0d overflowed.",
                 board.texts, board.with_opener, board.closed, board.spills);
        $display("Openers by kind single/triple-single/triple-double: %0d/%0d/%0d; %0d mismatches.",
                 board.kind_hits[0], board.kind_hits[1], board.kind_hits[2], board.errors);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
